/* rtl/core/q2e_pkg.sv */
// ----------------------------------------------------------------------------
// q2e_pkg
// shared widths, constants and the cordic arctangent steps of the
// quaternion to euler converter
// ----------------------------------------------------------------------------
package q2e_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN     = 24;
    localparam int CORDIC_NIT   = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
    localparam int NORM_N       = 6;
    localparam int CORDIC_LAT   = CORDIC_NIT + NORM_N + 2;

    localparam int COMP_W   = 16;
    localparam int TOL_W    = 16;
    localparam int S_DATA_W = 4 * COMP_W;
    localparam int ROLL_W   = 16;
    localparam int PITCH_W  = 15;
    localparam int YAW_W    = 17;
    localparam int M_DATA_W = ROLL_W + PITCH_W + YAW_W;
    localparam int CODE_W   = 2;

    localparam int CIN_W  = 35;
    localparam int MAG_W  = 41;
    localparam int NRM_W  = 42;
    localparam int ITER_W = 45;
    localparam int ANG_W  = 26;

    localparam logic signed [ANG_W-1:0] DEG180 = 26'sd11796480;

    // atan(2^-i) in units of 2^-16 degree
    function automatic logic signed [ANG_W-1:0] atan_step(input int i);
        logic signed [ANG_W-1:0] a;
        unique case (i)
            0:       a = 26'sd2949120;
            1:       a = 26'sd1740967;
            2:       a = 26'sd919879;
            3:       a = 26'sd466945;
            4:       a = 26'sd234379;
            5:       a = 26'sd117304;
            6:       a = 26'sd58666;
            7:       a = 26'sd29335;
            8:       a = 26'sd14668;
            9:       a = 26'sd7334;
            10:      a = 26'sd3667;
            11:      a = 26'sd1833;
            12:      a = 26'sd917;
            13:      a = 26'sd458;
            14:      a = 26'sd229;
            15:      a = 26'sd115;
            16:      a = 26'sd57;
            17:      a = 26'sd29;
            18:      a = 26'sd14;
            19:      a = 26'sd7;
            20:      a = 26'sd4;
            21:      a = 26'sd2;
            22:      a = 26'sd1;
            default: a = 26'sd0;
        endcase
        return a;
    endfunction

endpackage

/* rtl/core/q2e_cordic.sv */
// ----------------------------------------------------------------------------
// q2e_cordic
// pipelined vectoring cordic: atan2(y, x) in units of 2^-16 degree,
// with quadrant fold, staged normalization and saturation to +-180 degree
// ----------------------------------------------------------------------------
module q2e_cordic (
    input  logic                                aclk,
    input  logic                                en,
    input  logic signed [q2e_pkg::CIN_W-1:0]    y_in,
    input  logic signed [q2e_pkg::CIN_W-1:0]    x_in,
    output logic signed [q2e_pkg::ANG_W-1:0]    ang_out
);
    import q2e_pkg::*;

    logic signed [NRM_W-1:0]  nx_reg    [NORM_N+1];
    logic signed [NRM_W-1:0]  ny_reg    [NORM_N+1];
    logic        [MAG_W-1:0]  nm_reg    [NORM_N+1];
    logic signed [ANG_W-1:0]  nz_reg    [NORM_N+1];
    logic                     nzero_reg [NORM_N+1];

    logic signed [ITER_W-1:0] ix_reg    [CORDIC_NIT];
    logic signed [ITER_W-1:0] iy_reg    [CORDIC_NIT];
    logic signed [ANG_W-1:0]  iz_reg    [CORDIC_NIT];
    logic                     izero_reg [CORDIC_NIT];

    logic signed [ITER_W-1:0] ix    [CORDIC_NIT+1];
    logic signed [ITER_W-1:0] iy    [CORDIC_NIT+1];
    logic signed [ANG_W-1:0]  iz    [CORDIC_NIT+1];
    logic                     izero [CORDIC_NIT+1];

    logic signed [ANG_W-1:0]  ang_reg;

    logic                     in_neg;
    logic signed [CIN_W-1:0]  px;
    logic signed [CIN_W-1:0]  py;
    logic signed [CIN_W-1:0]  pya;
    logic        [MAG_W-1:0]  pm;
    logic signed [ANG_W-1:0]  pz;

    // fold the left half plane onto the right one
    always_comb begin
        in_neg = x_in[CIN_W-1];
        px     = in_neg ? -x_in : x_in;
        py     = in_neg ? -y_in : y_in;
        pya    = py[CIN_W-1] ? -py : py;
        pm     = (px > pya) ? MAG_W'($unsigned(px)) : MAG_W'($unsigned(pya));
        if (in_neg) begin
            pz = y_in[CIN_W-1] ? -DEG180 : DEG180;
        end else begin
            pz = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nx_reg[0]    <= NRM_W'(px);
            ny_reg[0]    <= NRM_W'(py);
            nm_reg[0]    <= pm;
            nz_reg[0]    <= pz;
            nzero_reg[0] <= (x_in == '0) && (y_in == '0);
        end
    end

    // leading zero normalization, one binary step per stage
    for (genvar j = 0; j < NORM_N; j++) begin : g_norm
        localparam int SH = 1 << (NORM_N - 1 - j);
        logic do_shift;
        assign do_shift = (nm_reg[j][MAG_W-1 -: SH] == '0);
        always_ff @(posedge aclk) begin
            if (en) begin
                if (do_shift) begin
                    nm_reg[j+1] <= nm_reg[j] << SH;
                    nx_reg[j+1] <= nx_reg[j] <<< SH;
                    ny_reg[j+1] <= ny_reg[j] <<< SH;
                end else begin
                    nm_reg[j+1] <= nm_reg[j];
                    nx_reg[j+1] <= nx_reg[j];
                    ny_reg[j+1] <= ny_reg[j];
                end
                nz_reg[j+1]    <= nz_reg[j];
                nzero_reg[j+1] <= nzero_reg[j];
            end
        end
    end

    assign ix[0]    = ITER_W'(nx_reg[NORM_N]);
    assign iy[0]    = ITER_W'(ny_reg[NORM_N]);
    assign iz[0]    = nz_reg[NORM_N];
    assign izero[0] = nzero_reg[NORM_N];

    for (genvar i = 0; i < CORDIC_NIT; i++) begin : g_iter
        assign ix[i+1]    = ix_reg[i];
        assign iy[i+1]    = iy_reg[i];
        assign iz[i+1]    = iz_reg[i];
        assign izero[i+1] = izero_reg[i];
        always_ff @(posedge aclk) begin
            if (en) begin
                if (iy[i] > 0) begin
                    ix_reg[i] <= ix[i] + (iy[i] >>> i);
                    iy_reg[i] <= iy[i] - (ix[i] >>> i);
                    iz_reg[i] <= iz[i] + atan_step(i);
                end else begin
                    ix_reg[i] <= ix[i] - (iy[i] >>> i);
                    iy_reg[i] <= iy[i] + (ix[i] >>> i);
                    iz_reg[i] <= iz[i] - atan_step(i);
                end
                izero_reg[i] <= izero[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (izero[CORDIC_NIT]) begin
                ang_reg <= '0;
            end else if (iz[CORDIC_NIT] > DEG180) begin
                ang_reg <= DEG180;
            end else if (iz[CORDIC_NIT] < -DEG180) begin
                ang_reg <= -DEG180;
            end else begin
                ang_reg <= iz[CORDIC_NIT];
            end
        end
    end

    assign ang_out = ang_reg;

endmodule

/* rtl/core/quaternion_to_euler.sv */
// ----------------------------------------------------------------------------
// quaternion_to_euler
// converts a quaternion (w, x, y, z in signed Q2.14, any length) into roll,
// pitch and yaw in units of 1/128 degree, with gimbal-lock detection
// ----------------------------------------------------------------------------
// Fully pipelined: one quaternion is taken per clock unless the output stalls.
// Each result passes through the chain of the products, a 31-stage restoring
// divider for the normalized test term, a squaring stage, a 31-stage square
// root and the 24-stage cordic (16 rotations) that gives pitch. A stall on
// m_tready freezes the whole pipeline. singularity_tolerance is written
// through cfg_wr_en and cfg_wr_data and resets to 168 (units of 2^-24).
module quaternion_to_euler (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [q2e_pkg::TOL_W-1:0]       cfg_wr_data,    // singularity_tolerance
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [q2e_pkg::S_DATA_W-1:0]    s_tdata,        // quat_w, quat_x, quat_y, quat_z
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [q2e_pkg::M_DATA_W-1:0]    m_tdata,        // roll_angle, pitch_angle, yaw_angle
    output logic [q2e_pkg::CODE_W-1:0]      m_tuser         // case_code
);
    import q2e_pkg::*;

    localparam int DIV_N   = 31;
    localparam int SQRT_N  = 31;
    localparam int IDX_C   = 2;
    localparam int IDX_P   = IDX_C + DIV_N + 3 + SQRT_N;
    localparam int ANG_DLY = IDX_P - IDX_C;
    localparam int IDX_OUT = IDX_P + CORDIC_LAT + 1;
    localparam int RI_W    = ANG_W + 2;
    localparam int RO_W    = RI_W - 9;

    localparam logic [CODE_W-1:0] CODE_NORMAL = 2'd0;
    localparam logic [CODE_W-1:0] CODE_POS90  = 2'd1;
    localparam logic [CODE_W-1:0] CODE_NEG90  = 2'd2;

    localparam logic [30:0] T_ONE   = 31'h4000_0000;
    localparam logic [24:0] T24_ONE = 25'h100_0000;
    localparam logic [60:0] C2_ONE  = 61'h1000_0000_0000_0000;

    localparam logic signed [PITCH_W-1:0] PITCH_UP = 15'sd11520;
    localparam logic signed [PITCH_W-1:0] PITCH_DN = -15'sd11520;

    typedef struct packed {
        logic [30:0]       t30;
        logic              neg;
        logic [CODE_W-1:0] code;
        logic              zero;
    } side_t;

    function automatic logic signed [RO_W-1:0] to_deg128(input logic signed [RI_W-1:0] a);
        logic signed [RI_W-1:0] s;
        s = a + $signed(RI_W'(256));
        return RO_W'(s >>> 9);
    endfunction

    logic                  adv;
    logic [IDX_OUT:0]      vld_reg;
    logic [TOL_W-1:0]      tol_reg;

    assign adv      = !vld_reg[IDX_OUT] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[IDX_OUT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[IDX_OUT-1:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= 16'd168;
        end else if (cfg_wr_en) begin
            tol_reg <= cfg_wr_data;
        end
    end

    // input register
    logic signed [COMP_W-1:0] a_w_reg, a_x_reg, a_y_reg, a_z_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_w_reg <= s_tdata[COMP_W-1:0];
            a_x_reg <= s_tdata[2*COMP_W-1:COMP_W];
            a_y_reg <= s_tdata[3*COMP_W-1:2*COMP_W];
            a_z_reg <= s_tdata[4*COMP_W-1:3*COMP_W];
        end
    end

    // products
    logic signed [2*COMP_W-1:0] b_ww_reg, b_xx_reg, b_yy_reg, b_zz_reg, b_yw_reg;
    logic signed [2*COMP_W-1:0] b_xz_reg, b_xy_reg, b_zw_reg, b_yz_reg, b_xw_reg;
    logic signed [COMP_W-1:0]   b_x_reg, b_w_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            b_ww_reg <= a_w_reg * a_w_reg;
            b_xx_reg <= a_x_reg * a_x_reg;
            b_yy_reg <= a_y_reg * a_y_reg;
            b_zz_reg <= a_z_reg * a_z_reg;
            b_yw_reg <= a_y_reg * a_w_reg;
            b_xz_reg <= a_x_reg * a_z_reg;
            b_xy_reg <= a_x_reg * a_y_reg;
            b_zw_reg <= a_z_reg * a_w_reg;
            b_yz_reg <= a_y_reg * a_z_reg;
            b_xw_reg <= a_x_reg * a_w_reg;
            b_x_reg  <= a_x_reg;
            b_w_reg  <= a_w_reg;
        end
    end

    // sums: norm, test term and the atan2 arguments
    logic signed [33:0] sum_n, sum_t, sum_ry, sum_rx, sum_yy, sum_yx;
    logic        [32:0] c_n_reg, c_mag_reg;
    logic               c_neg_reg, c_zero_reg;
    logic signed [CIN_W-1:0] c_roll_y_reg, c_roll_x_reg, c_yaw_y_reg, c_yaw_x_reg;
    logic signed [CIN_W-1:0] c_gy_reg, c_gx_reg;

    always_comb begin
        sum_n  = 34'(b_ww_reg) + 34'(b_xx_reg) + 34'(b_yy_reg) + 34'(b_zz_reg);
        sum_t  = (34'(b_yw_reg) - 34'(b_xz_reg)) <<< 1;
        sum_ry = (34'(b_yz_reg) + 34'(b_xw_reg)) <<< 1;
        sum_rx = 34'(b_ww_reg) + 34'(b_zz_reg) - 34'(b_xx_reg) - 34'(b_yy_reg);
        sum_yy = (34'(b_xy_reg) + 34'(b_zw_reg)) <<< 1;
        sum_yx = 34'(b_ww_reg) + 34'(b_xx_reg) - 34'(b_yy_reg) - 34'(b_zz_reg);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c_n_reg      <= sum_n[32:0];
            c_mag_reg    <= sum_t[33] ? 33'(-sum_t) : sum_t[32:0];
            c_neg_reg    <= sum_t[33];
            c_zero_reg   <= (sum_n == '0);
            c_roll_y_reg <= CIN_W'(sum_ry);
            c_roll_x_reg <= CIN_W'(sum_rx);
            c_yaw_y_reg  <= CIN_W'(sum_yy);
            c_yaw_x_reg  <= CIN_W'(sum_yx);
            c_gy_reg     <= CIN_W'(b_x_reg);
            c_gx_reg     <= CIN_W'(b_w_reg);
        end
    end

    logic signed [ANG_W-1:0] roll_ang, yaw_ang, gim_ang, pitch_ang;

    q2e_cordic u_roll (
        .aclk    (aclk),
        .en      (adv),
        .y_in    (c_roll_y_reg),
        .x_in    (c_roll_x_reg),
        .ang_out (roll_ang)
    );

    q2e_cordic u_yaw (
        .aclk    (aclk),
        .en      (adv),
        .y_in    (c_yaw_y_reg),
        .x_in    (c_yaw_x_reg),
        .ang_out (yaw_ang)
    );

    q2e_cordic u_gimbal (
        .aclk    (aclk),
        .en      (adv),
        .y_in    (c_gy_reg),
        .x_in    (c_gx_reg),
        .ang_out (gim_ang)
    );

    // restoring divider, one quotient bit per stage
    logic [32:0] dv_rem_reg  [DIV_N];
    logic [32:0] dv_n_reg    [DIV_N];
    logic [30:0] dv_q_reg    [DIV_N];
    logic        dv_neg_reg  [DIV_N];
    logic        dv_zero_reg [DIV_N];

    for (genvar k = 0; k < DIV_N; k++) begin : g_div
        if (k == 0) begin : g_first
            logic ge;
            assign ge = (c_mag_reg >= c_n_reg);
            always_ff @(posedge aclk) begin
                if (adv) begin
                    dv_rem_reg[k]  <= ge ? (c_mag_reg - c_n_reg) : c_mag_reg;
                    dv_q_reg[k]    <= {30'd0, ge};
                    dv_n_reg[k]    <= c_n_reg;
                    dv_neg_reg[k]  <= c_neg_reg;
                    dv_zero_reg[k] <= c_zero_reg;
                end
            end
        end else begin : g_step
            logic [33:0] r2;
            logic        ge;
            assign r2 = {dv_rem_reg[k-1], 1'b0};
            assign ge = (r2 >= {1'b0, dv_n_reg[k-1]});
            always_ff @(posedge aclk) begin
                if (adv) begin
                    dv_rem_reg[k]  <= ge ? 33'(r2 - {1'b0, dv_n_reg[k-1]}) : r2[32:0];
                    dv_q_reg[k]    <= {dv_q_reg[k-1][29:0], ge};
                    dv_n_reg[k]    <= dv_n_reg[k-1];
                    dv_neg_reg[k]  <= dv_neg_reg[k-1];
                    dv_zero_reg[k] <= dv_zero_reg[k-1];
                end
            end
        end
    end

    // clamp, gimbal-lock test, squaring and the radicand 1 - t^2
    logic [30:0] e_q, e_t30;
    logic [24:0] e_dist;
    logic        e_hit;
    side_t       e_side;
    side_t       e_reg, f_reg, g_reg;
    logic [60:0] f_sq_reg, g_rad_reg;
    logic [61:0] sq_full;

    always_comb begin
        e_q    = dv_q_reg[DIV_N-1];
        e_t30  = dv_zero_reg[DIV_N-1] ? '0 : ((e_q > T_ONE) ? T_ONE : e_q);
        e_dist = T24_ONE - e_t30[30:6];
        e_hit  = e_dist < 25'(tol_reg);
        e_side.t30  = e_t30;
        e_side.neg  = dv_neg_reg[DIV_N-1];
        e_side.zero = dv_zero_reg[DIV_N-1];
        if (e_hit && !dv_zero_reg[DIV_N-1]) begin
            e_side.code = dv_neg_reg[DIV_N-1] ? CODE_NEG90 : CODE_POS90;
        end else begin
            e_side.code = CODE_NORMAL;
        end
    end

    assign sq_full = e_reg.t30 * e_reg.t30;

    always_ff @(posedge aclk) begin
        if (adv) begin
            e_reg     <= e_side;
            f_reg     <= e_reg;
            f_sq_reg  <= sq_full[60:0];
            g_reg     <= f_reg;
            g_rad_reg <= C2_ONE - f_sq_reg;
        end
    end

    // square root, one result bit per stage
    logic [32:0] sr_rem_reg  [SQRT_N];
    logic [30:0] sr_root_reg [SQRT_N];
    logic [60:0] sr_rad_reg  [SQRT_N];
    side_t       sr_side_reg [SQRT_N];

    for (genvar j = 0; j < SQRT_N; j++) begin : g_sqrt
        logic [32:0] rem_in;
        logic [30:0] root_in;
        logic [60:0] rad_in;
        side_t       side_in;
        logic [61:0] rad62;
        logic [34:0] rem_sh, trial;
        logic        ge;
        if (j == 0) begin : g_src0
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = g_rad_reg;
            assign side_in = g_reg;
        end else begin : g_srcn
            assign rem_in  = sr_rem_reg[j-1];
            assign root_in = sr_root_reg[j-1];
            assign rad_in  = sr_rad_reg[j-1];
            assign side_in = sr_side_reg[j-1];
        end
        assign rad62  = {1'b0, rad_in};
        assign rem_sh = {rem_in, rad62[61-2*j -: 2]};
        assign trial  = {2'b00, root_in, 2'b01};
        assign ge     = (rem_sh >= trial);
        always_ff @(posedge aclk) begin
            if (adv) begin
                sr_rem_reg[j]  <= ge ? 33'(rem_sh - trial) : rem_sh[32:0];
                sr_root_reg[j] <= {root_in[29:0], ge};
                sr_rad_reg[j]  <= rad_in;
                sr_side_reg[j] <= side_in;
            end
        end
    end

    logic signed [CIN_W-1:0] p_y, p_x;
    side_t                   p_side;

    always_comb begin
        p_side = sr_side_reg[SQRT_N-1];
        p_x    = $signed(CIN_W'(sr_root_reg[SQRT_N-1]));
        p_y    = $signed(CIN_W'(p_side.t30));
        if (p_side.neg) begin
            p_y = -p_y;
        end
    end

    q2e_cordic u_pitch (
        .aclk    (aclk),
        .en      (adv),
        .y_in    (p_y),
        .x_in    (p_x),
        .ang_out (pitch_ang)
    );

    // align the early angles and the side band with pitch
    logic signed [ANG_W-1:0] rd_reg [ANG_DLY];
    logic signed [ANG_W-1:0] yd_reg [ANG_DLY];
    logic signed [ANG_W-1:0] gd_reg [ANG_DLY];
    side_t                   pd_reg [CORDIC_LAT];

    always_ff @(posedge aclk) begin
        if (adv) begin
            rd_reg[0] <= roll_ang;
            yd_reg[0] <= yaw_ang;
            gd_reg[0] <= gim_ang;
            for (int i = 1; i < ANG_DLY; i++) begin
                rd_reg[i] <= rd_reg[i-1];
                yd_reg[i] <= yd_reg[i-1];
                gd_reg[i] <= gd_reg[i-1];
            end
            pd_reg[0] <= p_side;
            for (int i = 1; i < CORDIC_LAT; i++) begin
                pd_reg[i] <= pd_reg[i-1];
            end
        end
    end

    // output register
    logic signed [ROLL_W-1:0]  out_roll_reg, o_roll;
    logic signed [PITCH_W-1:0] out_pitch_reg, o_pitch;
    logic signed [YAW_W-1:0]   out_yaw_reg, o_yaw;
    logic [CODE_W-1:0]         out_code_reg;
    side_t                     o_side;
    logic signed [RI_W-1:0]    o_g2;

    always_comb begin
        o_side = pd_reg[CORDIC_LAT-1];
        o_g2   = RI_W'(gd_reg[ANG_DLY-1]) <<< 1;
        o_roll  = '0;
        o_pitch = '0;
        o_yaw   = '0;
        if (!o_side.zero) begin
            unique case (o_side.code)
                CODE_POS90: begin
                    o_pitch = PITCH_UP;
                    o_yaw   = YAW_W'(to_deg128(-o_g2));
                end
                CODE_NEG90: begin
                    o_pitch = PITCH_DN;
                    o_yaw   = YAW_W'(to_deg128(o_g2));
                end
                default: begin
                    o_roll  = ROLL_W'(to_deg128(RI_W'(rd_reg[ANG_DLY-1])));
                    o_pitch = PITCH_W'(to_deg128(RI_W'(pitch_ang)));
                    o_yaw   = YAW_W'(to_deg128(RI_W'(yd_reg[ANG_DLY-1])));
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_roll_reg  <= o_roll;
            out_pitch_reg <= o_pitch;
            out_yaw_reg   <= o_yaw;
            out_code_reg  <= o_side.code;
        end
    end

    assign m_tdata = {out_yaw_reg, out_pitch_reg, out_roll_reg};
    assign m_tuser = out_code_reg;

endmodule

/* tb/sv/q2e_checker.sv */
// ----------------------------------------------------------------------------
// q2e_checker
// watches both channels of the quaternion to euler converter, predicts every
// result from the accepted quaternion and the current gimbal-lock tolerance,
// and compares each output transaction field by field in order
// ----------------------------------------------------------------------------
module q2e_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [q2e_pkg::TOL_W-1:0]       cfg_wr_data,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [q2e_pkg::S_DATA_W-1:0]    s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [q2e_pkg::M_DATA_W-1:0]    m_tdata,
    input  logic [q2e_pkg::CODE_W-1:0]      m_tuser,
    output int                              fail_count,
    output int                              pending
);
    import q2e_pkg::*;

    localparam logic [CODE_W-1:0] CASE_NORMAL     = 2'd0;
    localparam logic [CODE_W-1:0] CASE_PITCH_UP   = 2'd1;
    localparam logic [CODE_W-1:0] CASE_PITCH_DOWN = 2'd2;

    localparam longint HALF_TURN = 180 * 65536;
    localparam longint QTR_TURN  = 90 * 65536;
    localparam longint UNIT24    = longint'(1) << 24;

    localparam longint ARC_STEP [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    typedef struct packed {
        logic signed [ROLL_W-1:0]  roll;
        logic signed [PITCH_W-1:0] pitch;
        logic signed [YAW_W-1:0]   yaw;
        logic [CODE_W-1:0]         code;
    } angles_t;

    angles_t               angle_q[$];
    logic [TOL_W-1:0]      tolerance;

    function automatic longint vector_angle(longint ay, longint ax);
        longint ang, peak, xs, ys;
        ang = 0;
        if (ax == 0 && ay == 0)
            return 0;
        if (ax < 0) begin
            ang = (ay >= 0) ? HALF_TURN : -HALF_TURN;
            ax = -ax;
            ay = -ay;
        end
        peak = (ay < 0) ? -ay : ay;
        if (ax > peak)
            peak = ax;
        while (peak < (longint'(1) << 40)) begin
            peak = peak * 2;
            ax = ax * 2;
            ay = ay * 2;
        end
        for (int i = 0; i < CORDIC_NIT; i++) begin
            xs = ax >>> i;
            ys = ay >>> i;
            if (ay > 0) begin
                ax = ax + ys;
                ay = ay - xs;
                ang = ang + ARC_STEP[i];
            end else begin
                ax = ax - ys;
                ay = ay + xs;
                ang = ang - ARC_STEP[i];
            end
        end
        if (ang > HALF_TURN)
            ang = HALF_TURN;
        if (ang < -HALF_TURN)
            ang = -HALF_TURN;
        return ang;
    endfunction

    function automatic longint to_deg128(longint a);
        return (a + 256) >>> 9;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bits;
        res = 0;
        bits = longint'(1) << 62;
        while (bits > v)
            bits = bits >> 2;
        while (bits != 0) begin
            if (v >= res + bits) begin
                v = v - (res + bits);
                res = (res >> 1) + bits;
            end else begin
                res = res >> 1;
            end
            bits = bits >> 2;
        end
        return res;
    endfunction

    function automatic angles_t euler_of(logic [S_DATA_W-1:0] q, logic [TOL_W-1:0] tol);
        longint w, x, y, z, ww, xx, yy, zz, t, t30, t24, d, lim, roll, pitch, yaw;
        longint unsigned n, mag;
        angles_t r;
        w = longint'($signed(q[15:0]));
        x = longint'($signed(q[31:16]));
        y = longint'($signed(q[47:32]));
        z = longint'($signed(q[63:48]));
        ww = w * w; xx = x * x; yy = y * y; zz = z * z;
        n = ww + xx + yy + zz;
        t = 2 * (y * w - x * z);
        roll = 0; pitch = 0; yaw = 0;
        r.code = CASE_NORMAL;
        lim = longint'(tol);
        if (n != 0) begin
            mag = (t < 0) ? -t : t;
            t30 = longint'((mag << 30) / n);
            if (t30 > (longint'(1) << 30))
                t30 = longint'(1) << 30;
            t24 = t30 >>> 6;
            if (t < 0) begin
                t30 = -t30;
                t24 = -t24;
            end
            d = t24 - UNIT24;
            if (d < 0) d = -d;
            if (d < lim) begin
                r.code = CASE_PITCH_UP;
                pitch = to_deg128(QTR_TURN);
                yaw = to_deg128(-2 * vector_angle(x, w));
            end else begin
                d = t24 + UNIT24;
                if (d < 0) d = -d;
                if (d < lim) begin
                    r.code = CASE_PITCH_DOWN;
                    pitch = to_deg128(-QTR_TURN);
                    yaw = to_deg128(2 * vector_angle(x, w));
                end else begin
                    yaw = to_deg128(vector_angle(2 * (x * y + z * w), xx - yy - zz + ww));
                    roll = to_deg128(vector_angle(2 * (y * z + x * w), -xx - yy + zz + ww));
                    pitch = to_deg128(vector_angle(t30,
                        longint'(int_sqrt((longint'(1) << 60) - t30 * t30))));
                end
            end
        end
        r.roll = roll[ROLL_W-1:0];
        r.pitch = pitch[PITCH_W-1:0];
        r.yaw = yaw[YAW_W-1:0];
        return r;
    endfunction

    task automatic report(string field, longint want, longint got);
        $display("mismatch %s: expected %0d got %0d at %0t", field, want, got, $realtime);
        fail_count++;
    endtask

    assign pending = angle_q.size();

    initial fail_count = 0;

    always @(posedge aclk) begin
        angles_t want;
        angles_t got;
        if (!aresetn) begin
            tolerance <= 16'd168;
        end else begin
            if (cfg_wr_en)
                tolerance <= cfg_wr_data;
            if (s_tvalid && s_tready)
                angle_q.push_back(euler_of(s_tdata, tolerance));
            if (m_tvalid && m_tready) begin
                got.roll = m_tdata[ROLL_W-1:0];
                got.pitch = m_tdata[ROLL_W +: PITCH_W];
                got.yaw = m_tdata[ROLL_W+PITCH_W +: YAW_W];
                got.code = m_tuser;
                if (angle_q.size() == 0) begin
                    report("unexpected transaction", 0, 1);
                end else begin
                    want = angle_q.pop_front();
                    if (got.roll != want.roll)   report("roll", want.roll, got.roll);
                    if (got.pitch != want.pitch) report("pitch", want.pitch, got.pitch);
                    if (got.yaw != want.yaw)     report("yaw", want.yaw, got.yaw);
                    if (got.code != want.code)   report("case", want.code, got.code);
                end
            end
        end
    end

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// drives quaternions into the converter with random gaps and output stalls,
// steps the gimbal-lock tolerance through several values between phases,
// and lets the checker predict and compare every result
// ----------------------------------------------------------------------------
module testbench;
    import q2e_pkg::*;

    localparam int LATENCY   = 92;
    localparam int CYCLE_MAX = 400000;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [TOL_W-1:0]       cfg_wr_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_DATA_W-1:0]    m_tdata;
    logic [CODE_W-1:0]      m_tuser;
    int                     fail_count;
    int                     pending;
    int                     cycles;
    logic                   calm;
    logic                   hold_req;

    quaternion_to_euler dut (.*);

    q2e_checker checker_i (.*);

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_MAX) begin
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    // output side: random stall bursts, one long hold-off on request
    initial begin
        int n;
        m_tready = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 0;
                repeat (300) @(posedge aclk);
                hold_req <= 0;
                m_tready <= 1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 7);
                m_tready <= 0;
                repeat (n) @(posedge aclk);
                m_tready <= 1;
            end else begin
                m_tready <= 1;
            end
        end
    end

    task automatic send(logic signed [15:0] w, logic signed [15:0] x,
                        logic signed [15:0] y, logic signed [15:0] z);
        int n;
        if (!calm && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 7);
            s_tvalid <= 0;
            repeat (n) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {z, y, x, w};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain_and_set(logic [TOL_W-1:0] tol);
        s_tvalid <= 0;
        @(posedge aclk);
        wait (pending == 0);
        repeat (LATENCY + 8) @(posedge aclk);
        cfg_wr_en <= 1;
        cfg_wr_data <= tol;
        @(posedge aclk);
        cfg_wr_en <= 0;
    endtask

    task automatic send_random(int count);
        logic [15:0] a, b, c, d;
        int kind;
        for (int i = 0; i < count; i++) begin
            a = $urandom; b = $urandom; c = $urandom; d = $urandom;
            kind = $urandom_range(0, 9);
            if (kind < 3) begin
                // near gimbal lock: y close to +-w, x and z small
                c = (kind == 0) ? a : -a;
                c = c + 16'($signed($urandom_range(0, 16)) - 8);
                b = 16'($signed($urandom_range(0, 64)) - 32);
                d = 16'($signed($urandom_range(0, 64)) - 32);
            end else if (kind == 3) begin
                // exact lock with free x, z paired to keep yw - xz on the lock line
                c = (kind == 3 && $urandom_range(0, 1)) ? a : -a;
                d = ($signed(c) == $signed(a)) ? -b : b;
            end else if (kind == 4) begin
                a = a >>> 8; b = b >>> 8; c = c >>> 8; d = d >>> 8;
            end
            send(a, b, c, d);
        end
    endtask

    initial begin
        aresetn = 0;
        cfg_wr_en = 0;
        cfg_wr_data = '0;
        s_tvalid = 0;
        s_tdata = '0;
        calm = 0;
        hold_req = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        send(0, 0, 0, 0);
        send(16384, 0, 0, 0);
        send(-16384, 0, 0, 0);
        send(0, 16384, 0, 0);
        send(0, 0, 16384, 0);
        send(0, 0, 0, 16384);
        send(32767, 32767, 32767, 32767);
        send(-32768, -32768, -32768, -32768);
        send(-32768, 32767, -32768, 32767);
        send(32767, -32768, 0, 0);
        send(11585, 0, 11585, 0);
        send(11585, 0, -11585, 0);
        send(8192, 8192, 8192, -8192);
        send(8192, 8192, -8192, 8192);
        send(-8192, 8192, 8192, 8192);
        send(11585, 0, 11580, 0);
        send(-16384, 1, 0, 0);
        send(1, 0, 0, 0);
        send(0, 0, 0, -1);
        send(16384, 100, 16000, -50);

        drain_and_set(16'd0);
        send(11585, 0, 11585, 0);
        send(8192, 8192, -8192, 8192);
        send_random(150);

        drain_and_set(16'hFFFF);
        send(11585, 0, 11585, 0);
        send(16384, 0, 0, 0);
        send_random(200);

        // long output hold-off while input keeps being offered
        hold_req <= 1;
        send_random(250);

        drain_and_set(16'($urandom));
        send_random(200);

        drain_and_set(16'd1);
        send_random(150);

        drain_and_set(16'd168);
        send_random(150);
        calm = 1;
        send_random(100);

        s_tvalid <= 0;
        @(posedge aclk);
        wait (pending == 0);
        repeat (LATENCY + 20) @(posedge aclk);
        if (fail_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

/* files.f */
rtl/core/q2e_pkg.sv
rtl/core/q2e_cordic.sv
rtl/core/quaternion_to_euler.sv
tb/sv/q2e_checker.sv
tb/sv/testbench.sv
